/* hw/rtl/assert_macros.svh */
// Assertion macros for the RTL that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* hw/rtl/fyp_pkg.sv */
// Shared constants, types and helpers of the permutation table block.
`default_nettype none

package fyp_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int VAL_W       = 16;
  localparam int RAND_W      = 31;
  localparam int IDX_W       = 12;
  localparam int EXP_W       = 2;
  localparam int DIV_W       = ADDR_W + 1;
  localparam int CNT_W       = $clog2(RAND_W + 1);
  localparam int IN_TDATA_W  = ((RAND_W + IDX_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((VAL_W + 1 + 7) / 8) * 8;
  localparam int CFG_ADDR_W  = 1;

  // Operation codes carried in the input beat
  typedef enum logic [1:0] {
    OP_FILL  = 2'd0,
    OP_BEGIN = 2'd1,
    OP_SWAP  = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_SIZE_EXP = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_START    = 1'b1;

  // Request to the modulo unit
  typedef struct packed {
    logic              start;
    logic [RAND_W-1:0] dividend;
    logic [DIV_W-1:0]  divisor;
  } mod_req_t;

  // Answer of the modulo unit
  typedef struct packed {
    logic              done;
    logic [ADDR_W-1:0] rem;
  } mod_rsp_t;

  // Last index of the active table: 16^exp entries, clamped to the depth
  function automatic logic [ADDR_W-1:0] size_m1(input logic [EXP_W-1:0] exp);
    logic [31:0] sz;
    sz = 32'(1) << (4 * exp);
    if (sz > 32'(TABLE_DEPTH)) begin
      sz = 32'(TABLE_DEPTH);
    end
    return ADDR_W'(sz - 32'(1));
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/fisher_yates_permutation.sv */
// Top level: permutation table with fill, shuffle pass, swap step and read.
// Begin, or a swap on a done pass, posts at once; read reads the table, then posts;
//   fill writes all 16^e entries, then posts; a swap on an open pass runs the serial
//   modulo, two reads and two writes on the one table port, then posts the result.
// One item at a time: the next beat is taken the cycle after the result is posted,
//   later while an earlier result still waits in the output register for m_tready.
// Reset: synchronous; clears pass position and output valid, sets pass done,
//   loads exponent 3 and start value 0. The table is not cleared.
`default_nettype none

module fisher_yates_permutation (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  // Input beats
  input  wire logic                                   s_tvalid,
  output      logic                                   s_tready,
  input  wire logic [fyp_pkg::IN_TDATA_W-1:0]         s_tdata,  // random_word, read_index
  input  wire logic [1:0]                             s_tuser,  // operation
  // Result beats
  output      logic                                   m_tvalid,
  input  wire logic                                   m_tready,
  output      logic [fyp_pkg::OUT_TDATA_W-1:0]        m_tdata,  // read_value, pass_done
  // Configuration writes
  input  wire logic                                   cfg_we,
  input  wire logic [fyp_pkg::CFG_ADDR_W-1:0]         cfg_addr,
  input  wire logic [fyp_pkg::VAL_W-1:0]              cfg_data
);
  import fyp_pkg::*;

`include "assert_macros.svh"

  typedef enum logic [3:0] {
    S_IDLE, S_FILL, S_DIV, S_RD_I, S_RD_J, S_WR_I, S_WR_J, S_RD_OUT, S_POST
  } state_t;

  state_t            state;
  logic [EXP_W-1:0]  size_exp;
  logic [VAL_W-1:0]  start_value;
  logic [ADDR_W-1:0] swap_position;
  logic              done_flag;
  logic [ADDR_W-1:0] fill_cnt;
  logic [VAL_W-1:0]  val_i;
  logic [VAL_W-1:0]  res_value;
  logic              rd_ok;

  logic              accept;
  op_t               op;
  logic [RAND_W-1:0] random_word;
  logic [IDX_W-1:0]  read_index;
  logic [ADDR_W-1:0] last_idx;
  logic [ADDR_W-1:0] j_idx;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [VAL_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [VAL_W-1:0]  ram_rdata;

  mod_req_t          mod_req;
  mod_rsp_t          mod_rsp;

  // Unpack the input beat
  assign op          = op_t'(s_tuser);
  assign random_word = s_tdata[RAND_W-1:0];
  assign read_index  = s_tdata[RAND_W +: IDX_W];
  assign s_tready    = (state == S_IDLE);
  assign accept      = s_tvalid && s_tready;
  assign last_idx    = size_m1(size_exp);
  assign j_idx       = mod_rsp.rem;

  // Start the modulo unit on an accepted swap step while a pass is open
  assign mod_req.start    = accept && (op == OP_SWAP) && !done_flag;
  assign mod_req.dividend = random_word;
  assign mod_req.divisor  = {1'b0, swap_position} + DIV_W'(1);

  fyp_mod u_mod (
    .clk (clk),
    .rst (rst),
    .req (mod_req),
    .rsp (mod_rsp)
  );

  // Table port steering
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = swap_position;
    ram_wdata = ram_rdata;
    ram_raddr = swap_position;
    case (state)
      S_IDLE: ram_raddr = ADDR_W'(read_index);
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = fill_cnt;
        ram_wdata = start_value + VAL_W'(fill_cnt);
      end
      S_RD_I: ram_raddr = swap_position;
      S_RD_J: ram_raddr = j_idx;
      S_WR_I: begin
        ram_we    = 1'b1;
        ram_waddr = swap_position;
        ram_wdata = ram_rdata;
      end
      S_WR_J: begin
        ram_we    = 1'b1;
        ram_waddr = j_idx;
        ram_wdata = val_i;
      end
      default: ram_we = 1'b0;
    endcase
  end

  fyp_ram #(
    .WIDTH (VAL_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer, pass state, configuration and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_tvalid      <= 1'b0;
      swap_position <= '0;
      done_flag     <= 1'b1;
      size_exp      <= EXP_W'(3);
      start_value   <= '0;
    end else begin
      // Take configuration writes
      if (cfg_we) begin
        case (cfg_addr)
          CFG_SIZE_EXP: size_exp    <= cfg_data[EXP_W-1:0];
          CFG_START:    start_value <= cfg_data;
          default:      ;
        endcase
      end

      // Drop the output beat once taken; the post state drives valid itself
      if (m_tready && state != S_POST) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          res_value <= '0;
          if (accept) begin
            case (op)
              OP_FILL: begin
                fill_cnt <= '0;
                state    <= S_FILL;
              end
              OP_BEGIN: begin
                swap_position <= last_idx;
                done_flag     <= (last_idx == '0);
                state         <= S_POST;
              end
              OP_SWAP: begin
                state <= done_flag ? S_POST : S_DIV;
              end
              OP_READ: begin
                rd_ok <= ({1'b0, read_index} < (IDX_W + 1)'(TABLE_DEPTH));
                state <= S_RD_OUT;
              end
              default: state <= S_POST;
            endcase
          end
        end
        S_FILL: begin
          fill_cnt <= fill_cnt + ADDR_W'(1);
          if (fill_cnt == last_idx) begin
            swap_position <= last_idx;
            done_flag     <= (last_idx == '0);
            state         <= S_POST;
          end
        end
        S_DIV: begin
          if (mod_rsp.done) begin
            state <= S_RD_I;
          end
        end
        S_RD_I: state <= S_RD_J;
        S_RD_J: begin
          val_i <= ram_rdata;
          state <= S_WR_I;
        end
        S_WR_I: state <= S_WR_J;
        S_WR_J: begin
          swap_position <= swap_position - ADDR_W'(1);
          if (swap_position == ADDR_W'(1)) begin
            done_flag <= 1'b1;
          end
          state <= S_POST;
        end
        S_RD_OUT: begin
          res_value <= rd_ok ? ram_rdata : '0;
          state     <= S_POST;
        end
        S_POST: begin
          // Hold the result until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= OUT_TDATA_W'({done_flag, res_value});
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // An open pass never sits at position zero
  `ASSERT_IMP(a_open_pass_pos, !done_flag, swap_position != '0)
  // The modulo result stays below the divisor
  `ASSERT_IMP(a_mod_range, mod_rsp.done, {1'b0, mod_rsp.rem} <= {1'b0, swap_position})
  // One beat in flight: nothing is taken right after an accept
  `ASSERT_NEXT(a_one_in_flight, accept, !s_tready)

endmodule

`default_nettype wire

/* hw/rtl/fyp_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module fyp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hw/rtl/fyp_mod.sv */
// Bit-serial restoring modulo unit: one dividend bit per cycle.
`default_nettype none

module fyp_mod (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire fyp_pkg::mod_req_t req,
  output      fyp_pkg::mod_rsp_t rsp
);
  import fyp_pkg::*;

  logic              busy;
  logic              done;
  logic [CNT_W-1:0]  cnt;
  logic [RAND_W-1:0] quo;
  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  rem_next;
  logic [DIV_W-1:0]  divisor;
  logic [DIV_W:0]    trial;

  // Shift in the next dividend bit, subtract when the divisor fits
  always_comb begin
    trial = {rem, quo[RAND_W-1]};
    if (trial >= {1'b0, divisor}) begin
      rem_next = DIV_W'(trial - {1'b0, divisor});
    end else begin
      rem_next = DIV_W'(trial);
    end
  end

  // Load on start, advance one bit a cycle, pulse done after the last bit
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        quo     <= req.dividend;
        divisor <= req.divisor;
        rem     <= '0;
        cnt     <= CNT_W'(RAND_W);
        busy    <= 1'b1;
      end else if (busy) begin
        rem <= rem_next;
        quo <= quo << 1;
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.rem  = rem[ADDR_W-1:0];

endmodule

`default_nettype wire

/* test/tb_fisher_yates_permutation.sv */
// Testbench for the permutation table: directed rows, random shuffle passes, scoreboard.
`default_nettype none

module tb_fisher_yates_permutation;
  import fyp_pkg::*;

  localparam int ITEM_TARGET    = 550;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int END_PAUSE      = 50;

  typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

  // One directed row: an input beat or a register write, with an optional typed answer
  typedef struct packed {
    row_kind_t             kind;
    op_t                   op;
    logic [RAND_W-1:0]     rword;
    logic [IDX_W-1:0]      ridx;
    logic [CFG_ADDR_W-1:0] reg_idx;
    logic [VAL_W-1:0]      reg_val;
    logic                  typed;
    logic [VAL_W-1:0]      want_val;
    logic                  want_done;
  } dir_row_t;

  typedef struct packed {
    logic [VAL_W-1:0] rval;
    logic             done;
  } perm_out_t;

  localparam dir_row_t DIR_ROWS [28] = '{
    // swap right after reset: pass already done
    '{ROW_BEAT, OP_SWAP, 31'h0, 12'd0, CFG_SIZE_EXP, 16'h0, 1'b1, 16'h0000, 1'b1},
    // full-size fill, read both ends
    '{ROW_BEAT, OP_FILL, 31'h0, 12'd0, CFG_SIZE_EXP, 16'h0, 1'b1, 16'h0000, 1'b0},
    '{ROW_BEAT, OP_READ, 31'h0, 12'd0, CFG_SIZE_EXP, 16'h0, 1'b1, 16'h0000, 1'b0},
    '{ROW_BEAT, OP_READ, 31'h0, 12'd4095, CFG_SIZE_EXP, 16'h0, 1'b1, 16'h0fff, 1'b0},
    '{ROW_BEAT, OP_SWAP, 31'h7fffffff, 12'd0, CFG_SIZE_EXP, 16'h0, 1'b0, 16'h0, 1'b0},
    '{ROW_BEAT, OP_SWAP, 31'h0, 12'd0, CFG_SIZE_EXP, 16'h0, 1'b0, 16'h0, 1'b0},
    '{ROW_BEAT, OP_READ, 31'h0, 12'd0, CFG_SIZE_EXP, 16'h0, 1'b0, 16'h0, 1'b0},
    // shrink to one entry mid-pass: the pass keeps going
    '{ROW_CFG, OP_FILL, 31'h0, 12'd0, CFG_SIZE_EXP, 16'd0, 1'b0, 16'h0, 1'b0},
    '{ROW_BEAT, OP_SWAP, 31'h5, 12'd0, CFG_SIZE_EXP, 16'h0, 1'b0, 16'h0, 1'b0},
    '{ROW_BEAT, OP_BEGIN, 31'h0, 12'd0, CFG_SIZE_EXP, 16'h0, 1'b1, 16'h0000, 1'b1},
    '{ROW_BEAT, OP_SWAP, 31'h7fffffff, 12'd0, CFG_SIZE_EXP, 16'h0, 1'b1, 16'h0000, 1'b1},
    '{ROW_BEAT, OP_FILL, 31'h0, 12'd0, CFG_SIZE_EXP, 16'h0, 1'b1, 16'h0000, 1'b1},
    '{ROW_BEAT, OP_READ, 31'h0, 12'd0, CFG_SIZE_EXP, 16'h0, 1'b1, 16'h0000, 1'b1},
    // sixteen entries with fill values wrapping past 16 bits
    '{ROW_CFG, OP_FILL, 31'h0, 12'd0, CFG_START, 16'hfff8, 1'b0, 16'h0, 1'b0},
    '{ROW_CFG, OP_FILL, 31'h0, 12'd0, CFG_SIZE_EXP, 16'd1, 1'b0, 16'h0, 1'b0},
    '{ROW_BEAT, OP_FILL, 31'h0, 12'd0, CFG_SIZE_EXP, 16'h0, 1'b1, 16'h0000, 1'b0},
    '{ROW_BEAT, OP_READ, 31'h0, 12'd15, CFG_SIZE_EXP, 16'h0, 1'b1, 16'h0007, 1'b0},
    '{ROW_BEAT, OP_READ, 31'h0, 12'd100, CFG_SIZE_EXP, 16'h0, 1'b1, 16'h0064, 1'b0},
    '{ROW_BEAT, OP_SWAP, 31'h7fffffff, 12'd0, CFG_SIZE_EXP, 16'h0, 1'b0, 16'h0, 1'b0},
    '{ROW_BEAT, OP_SWAP, 31'h2aaaaaaa, 12'd0, CFG_SIZE_EXP, 16'h0, 1'b0, 16'h0, 1'b0},
    '{ROW_BEAT, OP_SWAP, 31'h55555555, 12'd0, CFG_SIZE_EXP, 16'h0, 1'b0, 16'h0, 1'b0},
    '{ROW_BEAT, OP_BEGIN, 31'h0, 12'd0, CFG_SIZE_EXP, 16'h0, 1'b1, 16'h0000, 1'b0},
    '{ROW_BEAT, OP_READ, 31'h0, 12'd0, CFG_SIZE_EXP, 16'h0, 1'b0, 16'h0, 1'b0},
    // 256 entries starting at the top value
    '{ROW_CFG, OP_FILL, 31'h0, 12'd0, CFG_SIZE_EXP, 16'd2, 1'b0, 16'h0, 1'b0},
    '{ROW_CFG, OP_FILL, 31'h0, 12'd0, CFG_START, 16'hffff, 1'b0, 16'h0, 1'b0},
    '{ROW_BEAT, OP_FILL, 31'h0, 12'd0, CFG_SIZE_EXP, 16'h0, 1'b1, 16'h0000, 1'b0},
    '{ROW_BEAT, OP_READ, 31'h0, 12'd255, CFG_SIZE_EXP, 16'h0, 1'b1, 16'h00fe, 1'b0},
    '{ROW_BEAT, OP_READ, 31'h0, 12'd0, CFG_SIZE_EXP, 16'h0, 1'b1, 16'hffff, 1'b0}
  };

  logic                        clk      = 1'b0;
  logic                        rst      = 1'b1;
  logic                        s_tvalid = 1'b0;
  logic                        s_tready;
  logic [IN_TDATA_W-1:0]       s_tdata  = '0;
  logic [1:0]                  s_tuser  = '0;
  logic                        m_tvalid;
  logic                        m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]      m_tdata;
  logic                        cfg_we   = 1'b0;
  logic [CFG_ADDR_W-1:0]       cfg_addr = '0;
  logic [VAL_W-1:0]            cfg_data = '0;

  // Shadow copy of the block state and registers
  logic [VAL_W-1:0]  shadow_tbl [TABLE_DEPTH];
  logic [IDX_W-1:0]  shadow_pos   = '0;
  logic              shadow_done  = 1'b1;
  logic [EXP_W-1:0]  shadow_exp   = EXP_W'(3);
  logic [VAL_W-1:0]  shadow_start = '0;

  perm_out_t perm_results_q [$];
  perm_out_t want;
  int        mismatches  = 0;
  int        beats_sent  = 0;
  int        send_run    = 0;
  int        recv_run    = 0;
  int        recv_count  = 0;
  int        idle_cycles = 0;

  fisher_yates_permutation dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // random_word, read_index
    .s_tuser  (s_tuser),   // operation
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // read_value, pass_done
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Advance the shadow table by one operation and return its result
  function automatic void apply_table_op(input op_t op, input logic [RAND_W-1:0] rword,
                                         input logic [IDX_W-1:0] ridx,
                                         output perm_out_t res);
    int unsigned sz;
    int unsigned pos;
    int unsigned j;
    int unsigned i;
    logic [VAL_W-1:0] held;
    sz = 32'd1 << (4 * int'(shadow_exp));
    if (sz > TABLE_DEPTH) begin
      sz = TABLE_DEPTH;
    end
    res.rval = '0;
    case (op)
      OP_FILL: begin
        for (i = 0; i < sz; i++) shadow_tbl[i] = shadow_start + VAL_W'(i);
      end
      OP_SWAP: begin
        if (!shadow_done) begin
          pos = shadow_pos;
          j = rword % (pos + 1);
          held = shadow_tbl[pos];
          shadow_tbl[pos] = shadow_tbl[j];
          shadow_tbl[j] = held;
          shadow_pos = shadow_pos - 1'b1;
          if (shadow_pos == 0) shadow_done = 1'b1;
        end
      end
      OP_READ: begin
        res.rval = shadow_tbl[ridx];
      end
      default: ;
    endcase
    // fill and begin both restart the pass at the top of the active size
    if (op == OP_FILL || op == OP_BEGIN) begin
      shadow_pos  = IDX_W'(sz - 1);
      shadow_done = (sz == 1);
    end
    res.done = shadow_done;
  endfunction

  // Idle cycles before the next beat; now and then a run with no idling
  function automatic int draw_gap(inout int run);
    if (run > 0) begin
      run--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      run = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 9);
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    if ($urandom_range(0, 1) == 0) return IDX_W'($urandom);
    return IDX_W'($urandom_range(0, 15));
  endfunction

  // Offer one input beat, then predict its result once taken
  task automatic send_beat(input op_t op, input logic [RAND_W-1:0] rword,
                           input logic [IDX_W-1:0] ridx, input logic typed,
                           input logic [VAL_W-1:0] tval, input logic tdone);
    int gap;
    perm_out_t res;
    gap = draw_gap(send_run);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= IN_TDATA_W'({ridx, rword});
    do @(posedge clk); while (!s_tready);
    apply_table_op(op, rword, ridx, res);
    if (typed) begin
      res.rval = tval;
      res.done = tdone;
    end
    perm_results_q.push_back(res);
    beats_sent++;
  endtask

  // Write a register once every pending result has drained
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [VAL_W-1:0] data);
    s_tvalid <= 1'b0;
    while (perm_results_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SIZE_EXP) shadow_exp = data[EXP_W-1:0];
    else shadow_start = data;
  endtask

  // Stimulus: directed rows, then random shuffle passes
  initial begin : stimulus
    int nsteps;
    int pick;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (DIR_ROWS[n]) begin
      if (DIR_ROWS[n].kind == ROW_CFG) begin
        write_reg(DIR_ROWS[n].reg_idx, DIR_ROWS[n].reg_val);
      end else begin
        send_beat(DIR_ROWS[n].op, DIR_ROWS[n].rword, DIR_ROWS[n].ridx, DIR_ROWS[n].typed,
                  DIR_ROWS[n].want_val, DIR_ROWS[n].want_done);
      end
    end

    while (beats_sent < ITEM_TARGET) begin
      // mostly 16 entries; sometimes keep the size so an open pass carries on
      pick = $urandom_range(0, 19);
      if ($urandom_range(0, 2) != 0) begin
        write_reg(CFG_SIZE_EXP, (pick == 0) ? 16'd0 : (pick == 1) ? 16'd3 :
                                (pick < 4) ? 16'd2 : 16'd1);
      end
      if ($urandom_range(0, 3) == 0) write_reg(CFG_START, VAL_W'($urandom));

      pick = $urandom_range(0, 9);
      if (pick < 7) send_beat(OP_FILL, RAND_W'($urandom), pick_index(), 1'b0, '0, 1'b0);
      else if (pick < 9) send_beat(OP_BEGIN, RAND_W'($urandom), pick_index(), 1'b0, '0, 1'b0);

      if (shadow_exp <= 1) nsteps = (1 << (4 * int'(shadow_exp))) - 1 + $urandom_range(0, 3);
      else nsteps = $urandom_range(4, 24);

      for (int k = 0; k < nsteps; k++) begin
        if ($urandom_range(0, 4) == 0) begin
          send_beat(OP_READ, RAND_W'($urandom), pick_index(), 1'b0, '0, 1'b0);
        end
        if ($urandom_range(0, 15) == 0) begin
          send_beat(op_t'($urandom_range(0, 3)), RAND_W'($urandom), pick_index(),
                    1'b0, '0, 1'b0);
        end
        send_beat(OP_SWAP, RAND_W'($urandom), pick_index(), 1'b0, '0, 1'b0);
      end
      repeat ($urandom_range(1, 3)) begin
        send_beat(OP_READ, RAND_W'($urandom), pick_index(), 1'b0, '0, 1'b0);
      end
    end

    // Drain and settle
    s_tvalid <= 1'b0;
    while (perm_results_q.size() != 0) @(posedge clk);
    repeat (END_PAUSE) @(posedge clk);
    if (mismatches == 0 && perm_results_q.size() == 0) begin
      $display("** fisher_yates_permutation: PASSED **");
    end else begin
      $display("** fisher_yates_permutation: FAILED **");
    end
    $finish;
  end

  // Result side: random stalls plus a few long hold-offs to back the block up
  initial begin : receiver
    int gap;
    do @(posedge clk); while (rst);
    forever begin
      if (recv_count == 30 || recv_count == 300 || recv_count == 450) gap = HOLD_CYCLES;
      else gap = draw_gap(recv_run);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      recv_count++;
    end
  end

  // Compare each result beat with the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (perm_results_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: tdata %h", m_tdata);
      end else begin
        want = perm_results_q.pop_front();
        if (m_tdata[VAL_W-1:0] !== want.rval || m_tdata[VAL_W] !== want.done) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected value %h done %b, got value %h done %b",
                     want.rval, want.done, m_tdata[VAL_W-1:0], m_tdata[VAL_W]);
          end
        end
      end
    end
  end

  // Watchdog: end the run after too long without any beat moving
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** fisher_yates_permutation: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

`default_nettype wire
